### hw/rtl/rc4_stream_cipher_top_defines.svh
// assertion macros for the rc4 rtl, used by the controller
`ifndef RC4_STREAM_CIPHER_TOP_DEFINES_SVH
`define RC4_STREAM_CIPHER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RC4_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rc4 check failed");
`define RC4_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("rc4 reset check failed");
`else
`define RC4_ASSERT(label, prop)
`define RC4_ASSERT_RST(label, prop)
`endif
`endif

### hw/rtl/rc4_pkg.sv
`default_nettype none
package rc4_pkg;

   localparam int unsigned CFG_W     = 9;
   localparam int unsigned DATA_W    = 8;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned MOD_W     = 10;
   localparam int unsigned MOD_CMP_W = 18;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned SH_W      = 4;

   localparam logic [CFG_W-1:0] STATE_SIZE_RESET = 9'd256;
   localparam logic [CFG_W-1:0] KEY_LENGTH_RESET = 9'd16;
   localparam logic [CFG_W-1:0] KEY_DEPTH        = 9'd256;

   // the reducer walks shift amounts 8 down to 0, three per pass
   localparam logic [SH_W-1:0] MOD_SH_TOP  = 4'd8;
   localparam logic [SH_W-1:0] MOD_SH_LAST = 4'd2;
   localparam logic [SH_W-1:0] MOD_SH_STEP = 4'd3;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_STATE,
      KIND_LOAD_KEY,
      KIND_SCHEDULE,
      KIND_ENCRYPT
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STATE_SIZE,
      CSR_KEY_LENGTH
   } csr_index_type;

   typedef enum logic [1:0] {SR_NONE, SR_I, SR_J, SR_SEL} state_rd_type;
   typedef enum logic [1:0] {SW_NONE, SW_LOAD, SW_I, SW_J} state_wr_type;
   typedef enum logic [1:0] {MX_KS, MX_I, MX_J, MX_SEL} mod_src_type;
   typedef enum logic [1:0] {DST_NONE, DST_I, DST_J, DST_SEL} mod_dst_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_KS_RD,
      ST_KS_MOD,
      ST_KS_MODW,
      ST_KS_RDJ,
      ST_KS_WI,
      ST_KS_WJ,
      ST_GI_MOD,
      ST_GI_MODW,
      ST_G_RDI,
      ST_GJ_MOD,
      ST_GJ_MODW,
      ST_G_RDJ,
      ST_G_WI,
      ST_G_WJ,
      ST_GS_MOD,
      ST_GS_MODW,
      ST_G_RDS,
      ST_G_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic         capture;
      state_rd_type state_rd;
      logic         key_rd;
      state_wr_type state_wr;
      logic         key_wr;
      logic         mod_start;
      mod_src_type  mod_src;
      mod_dst_type  mod_dst;
      logic         ks_init;
      logic         ks_next;
      logic         gen_clear;
      logic         rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     mod_done;
      logic     ks_last;
      logic     rsp_free;
   } dp_status_type;

   // one restoring step: subtract n << sh when it fits
   function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] rem,
                                                 input logic [CFG_W-1:0] n,
                                                 input logic [SH_W-1:0] sh);
      logic [MOD_CMP_W-1:0] d;
      logic [MOD_W-1:0]     res;
      d   = {{(MOD_CMP_W-CFG_W){1'b0}}, n} << sh;
      res = rem;
      if ({{(MOD_CMP_W-MOD_W){1'b0}}, rem} >= d) begin
         res = rem - d[MOD_W-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/rc4_mod.sv
`default_nettype none
module rc4_mod (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rc4_pkg::MOD_W-1:0]  x,
   input  wire logic [rc4_pkg::CFG_W-1:0]  n,
   output logic                            done,
   output logic [rc4_pkg::DATA_W-1:0]      r
);
   import rc4_pkg::*;

   logic [MOD_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]  sh_ff, sh_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [MOD_W-1:0] r1, r2, r3;

   // x < 1024 and n >= 2, so n << 9 never fits and the walk starts at 8
   always_comb begin
      r1 = mod_step(rem_ff, n, sh_ff);
      r2 = mod_step(r1, n, sh_ff - 4'd1);
      r3 = mod_step(r2, n, sh_ff - 4'd2);
   end

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = x;
         sh_in   = MOD_SH_TOP;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = r3;
         if (sh_ff == MOD_SH_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            sh_in = sh_ff - MOD_SH_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_ff   <= MOD_SH_TOP;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         sh_ff   <= sh_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   // remainder is below n <= 256
   assign r    = rem_ff[DATA_W-1:0];
   assign done = done_ff;

endmodule
`default_nettype wire

### hw/rtl/rc4_dp.sv
`default_nettype none
module rc4_dp #(
   parameter int MAX_STATE = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rc4_pkg::dp_cmd_type           cmd,
   output rc4_pkg::dp_status_type             status,
   input  wire logic [rc4_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [rc4_pkg::DATA_W-1:0]    req_index,
   input  wire logic [rc4_pkg::DATA_W-1:0]    req_value,
   input  wire logic                          csr_write,
   input  wire logic [rc4_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rc4_pkg::CFG_W-1:0]     csr_data,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [2*rc4_pkg::DATA_W-1:0]       rsp_tdata
);
   import rc4_pkg::*;

   localparam int AW = (MAX_STATE > 1) ? $clog2(MAX_STATE) : 1;
   localparam logic [CFG_W-1:0] MaxN = CFG_W'(MAX_STATE);

   logic [DATA_W-1:0] state_mem [MAX_STATE];
   logic [DATA_W-1:0] key_mem [256];

   logic [CFG_W-1:0]    state_size_ff, key_length_ff;
   kind_type            kind_ff;
   logic [DATA_W-1:0]   index_ff, value_ff;
   logic [DATA_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic [DATA_W-1:0]   kidx_ff, kidx_in;
   logic [DATA_W-1:0]   si_ff, sj_ff, kv_ff, ks_ff, sel_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2*DATA_W-1:0] rsp_data_ff;

   logic [CFG_W-1:0]  n_eff, k_eff;
   logic [MOD_W-1:0]  mod_x;
   logic              mod_done;
   logic [DATA_W-1:0] mod_r;
   logic              s_we;
   logic [AW-1:0]     s_waddr;
   logic [DATA_W-1:0] s_wdata;
   logic              k_we;
   logic [CFG_W-1:0]  kidx_inc;

   always_comb begin
      n_eff = state_size_ff;
      if (state_size_ff < 9'd2) begin
         n_eff = 9'd2;
      end else if (state_size_ff > MaxN) begin
         n_eff = MaxN;
      end
      k_eff = key_length_ff;
      if (key_length_ff == 9'd0) begin
         k_eff = 9'd1;
      end else if (key_length_ff > KEY_DEPTH) begin
         k_eff = KEY_DEPTH;
      end
   end

   always_comb begin
      case (cmd.mod_src)
         MX_KS:   mod_x = {2'b00, j_ff} + {2'b00, si_ff} + {2'b00, kv_ff};
         MX_I:    mod_x = {2'b00, i_ff} + 10'd1;
         MX_J:    mod_x = {2'b00, j_ff} + {2'b00, si_ff};
         MX_SEL:  mod_x = {2'b00, si_ff} + {2'b00, sj_ff};
         default: mod_x = '0;
      endcase
   end

   rc4_mod u_mod (
      .clock (clock),
      .reset (reset),
      .start (cmd.mod_start),
      .x     (mod_x),
      .n     (n_eff),
      .done  (mod_done),
      .r     (mod_r)
   );

   // state store write port: loads, then the two halves of a swap
   always_comb begin
      s_we    = 1'b0;
      s_waddr = i_ff[AW-1:0];
      s_wdata = sj_ff;
      case (cmd.state_wr)
         SW_LOAD: begin
            s_we    = ({1'b0, index_ff} < n_eff);
            s_waddr = index_ff[AW-1:0];
            s_wdata = value_ff;
         end
         SW_I: begin
            s_we    = 1'b1;
            s_waddr = i_ff[AW-1:0];
            s_wdata = sj_ff;
         end
         SW_J: begin
            s_we    = 1'b1;
            s_waddr = j_ff[AW-1:0];
            s_wdata = si_ff;
         end
         default: s_we = 1'b0;
      endcase
   end

   assign k_we     = cmd.key_wr && ({1'b0, index_ff} < k_eff);
   assign kidx_inc = {1'b0, kidx_ff} + 9'd1;

   always_ff @(posedge clock) begin
      if (s_we) begin
         state_mem[s_waddr] <= s_wdata;
      end
      case (cmd.state_rd)
         SR_I:    si_ff <= state_mem[i_ff[AW-1:0]];
         SR_J:    sj_ff <= state_mem[j_ff[AW-1:0]];
         SR_SEL:  ks_ff <= state_mem[sel_ff[AW-1:0]];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (k_we) begin
         key_mem[index_ff] <= value_ff;
      end
      if (cmd.key_rd) begin
         kv_ff <= key_mem[kidx_ff];
      end
   end

   always_comb begin
      i_in    = i_ff;
      j_in    = j_ff;
      kidx_in = kidx_ff;
      if (cmd.ks_init || cmd.gen_clear) begin
         i_in    = '0;
         j_in    = '0;
         kidx_in = '0;
      end else begin
         if (cmd.ks_next) begin
            i_in    = i_ff + 8'd1;
            kidx_in = (kidx_inc == k_eff) ? '0 : kidx_inc[DATA_W-1:0];
         end
         if (cmd.mod_dst == DST_I) begin
            i_in = mod_r;
         end
         if (cmd.mod_dst == DST_J) begin
            j_in = mod_r;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_size_ff <= STATE_SIZE_RESET;
         key_length_ff <= KEY_LENGTH_RESET;
         i_ff          <= '0;
         j_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_STATE_SIZE: state_size_ff <= csr_data;
               CSR_KEY_LENGTH: key_length_ff <= csr_data;
               default: ;
            endcase
         end
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kidx_ff <= kidx_in;
      if (cmd.capture) begin
         kind_ff  <= kind_type'(req_kind);
         index_ff <= req_index;
         value_ff <= req_value;
      end
      if (cmd.mod_dst == DST_SEL) begin
         sel_ff <= mod_r;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= {ks_ff, value_ff ^ ks_ff};
      end
   end

   assign status.kind     = kind_ff;
   assign status.mod_done = mod_done;
   assign status.ks_last  = ({1'b0, i_ff} == (n_eff - 9'd1));
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

### hw/rtl/rc4_ctrl.sv
`default_nettype none
`include "rc4_stream_cipher_top_defines.svh"
module rc4_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire rc4_pkg::dp_status_type  status,
   output rc4_pkg::dp_cmd_type          cmd
);
   import rc4_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.capture    = 1'b0;
      cmd.state_rd   = SR_NONE;
      cmd.key_rd     = 1'b0;
      cmd.state_wr   = SW_NONE;
      cmd.key_wr     = 1'b0;
      cmd.mod_start  = 1'b0;
      cmd.mod_src    = MX_KS;
      cmd.mod_dst    = DST_NONE;
      cmd.ks_init    = 1'b0;
      cmd.ks_next    = 1'b0;
      cmd.gen_clear  = 1'b0;
      cmd.rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.kind)
               KIND_LOAD_STATE: begin
                  cmd.state_wr = SW_LOAD;
                  state_in     = ST_IDLE;
               end
               KIND_LOAD_KEY: begin
                  cmd.key_wr = 1'b1;
                  state_in   = ST_IDLE;
               end
               KIND_SCHEDULE: begin
                  cmd.ks_init = 1'b1;
                  state_in    = ST_KS_RD;
               end
               default: state_in = ST_GI_MOD;
            endcase
         end
         // key schedule, one state entry per pass
         ST_KS_RD: begin
            cmd.state_rd = SR_I;
            cmd.key_rd   = 1'b1;
            state_in     = ST_KS_MOD;
         end
         ST_KS_MOD: begin
            cmd.mod_start = 1'b1;
            cmd.mod_src   = MX_KS;
            state_in      = ST_KS_MODW;
         end
         ST_KS_MODW: begin
            if (status.mod_done) begin
               cmd.mod_dst = DST_J;
               state_in    = ST_KS_RDJ;
            end
         end
         ST_KS_RDJ: begin
            cmd.state_rd = SR_J;
            state_in     = ST_KS_WI;
         end
         ST_KS_WI: begin
            cmd.state_wr = SW_I;
            state_in     = ST_KS_WJ;
         end
         ST_KS_WJ: begin
            cmd.state_wr = SW_J;
            if (status.ks_last) begin
               cmd.gen_clear = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.ks_next = 1'b1;
               state_in    = ST_KS_RD;
            end
         end
         // generator step
         ST_GI_MOD: begin
            cmd.mod_start = 1'b1;
            cmd.mod_src   = MX_I;
            state_in      = ST_GI_MODW;
         end
         ST_GI_MODW: begin
            if (status.mod_done) begin
               cmd.mod_dst = DST_I;
               state_in    = ST_G_RDI;
            end
         end
         ST_G_RDI: begin
            cmd.state_rd = SR_I;
            state_in     = ST_GJ_MOD;
         end
         ST_GJ_MOD: begin
            // (j mod n + s[i]) mod n folds into one reduction
            cmd.mod_start = 1'b1;
            cmd.mod_src   = MX_J;
            state_in      = ST_GJ_MODW;
         end
         ST_GJ_MODW: begin
            if (status.mod_done) begin
               cmd.mod_dst = DST_J;
               state_in    = ST_G_RDJ;
            end
         end
         ST_G_RDJ: begin
            cmd.state_rd = SR_J;
            state_in     = ST_G_WI;
         end
         ST_G_WI: begin
            cmd.state_wr = SW_I;
            state_in     = ST_G_WJ;
         end
         ST_G_WJ: begin
            cmd.state_wr = SW_J;
            state_in     = ST_GS_MOD;
         end
         ST_GS_MOD: begin
            cmd.mod_start = 1'b1;
            cmd.mod_src   = MX_SEL;
            state_in      = ST_GS_MODW;
         end
         ST_GS_MODW: begin
            if (status.mod_done) begin
               cmd.mod_dst = DST_SEL;
               state_in    = ST_G_RDS;
            end
         end
         ST_G_RDS: begin
            cmd.state_rd = SR_SEL;
            state_in     = ST_G_OUT;
         end
         ST_G_OUT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `RC4_ASSERT(a_rsp_slot_free, cmd.rsp_load |-> status.rsp_free)
   `RC4_ASSERT(a_mod_result_ready, (cmd.mod_dst != DST_NONE) |-> status.mod_done)
   `RC4_ASSERT(a_accept_decodes, (req_tvalid && req_tready) |=> (state_ff == ST_DECODE))
   `RC4_ASSERT(a_swap_after_read, (cmd.state_wr == SW_I) |-> ($past(cmd.state_rd) == SR_J))
   `RC4_ASSERT_RST(a_reset_idle, reset |=> (state_ff == ST_IDLE))

endmodule
`default_nettype wire

### hw/rtl/rc4_stream_cipher_top.sv
// rc4 stream cipher over a state of n entries with a loaded initial permutation
// req channel: one beat per command; tuser is the command kind (load state
// entry, load key entry, run key schedule, encrypt); tdata carries index and value
// rsp channel: one beat per encrypt command with the cipher and keystream bytes
// csr channel: writes state_size (index 0) or key_length (index 1); the user must write
// only while idle, as the block does not enforce it; csr_ready is always high
// a load is written in the decode state, then the block returns to idle
// key schedule per state entry: read s[i] and a key byte, reduce j, read s[j],
// then write s[i] and s[j]; an encrypt reduces i, j and the keystream index in turn,
// then waits for a free rsp slot; the next command is accepted after its beat loads
// the pace is set by the shared modulo-n reducer (three passes plus handoff, used
// three times per byte) and the single write port of the state store
// a stalled rsp beat holds in the output register; further commands are still
// accepted and only the next encrypt result waits for the register to drain
// reset clears the generator indices and restores state_size 256 and
// key_length 16; the state and key stores must be loaded before use
`default_nettype none
module rc4_stream_cipher_top #(
   parameter int MAX_STATE = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // index [7:0], value [15:8]
   input  wire logic [1:0]  req_tuser,   // kind [1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // cipher_value [7:0], keystream_value [15:8]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [rc4_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rc4_pkg::CFG_W-1:0]     csr_data
);
   import rc4_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rc4_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rc4_dp #(
      .MAX_STATE (MAX_STATE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_kind   (req_tuser),
      .req_index  (req_tdata[7:0]),
      .req_value  (req_tdata[15:8]),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
